[rtl/core/encoder_angle_current_front_end_unit_defines.svh]
// assertion macros shared by the checker files of the encoder front end
// no dependencies; included by eacfe_chk.sv
`ifndef ENCODER_ANGLE_CURRENT_FRONT_END_UNIT_DEFINES_SVH
`define ENCODER_ANGLE_CURRENT_FRONT_END_UNIT_DEFINES_SVH

// concurrent check, switched off while reset is asserted
`define EACFE_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define EACFE_CHECK_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/eacfe_pkg.sv]
// types, register indexes, reset values and saturation helpers of the encoder front end
// no dependencies; imported by every module of the block
package eacfe_pkg;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 96;

	localparam int ANGLE_SHIFT   = 9;
	// ((zero-adc) << 3) * gain >> 14 folds into one shift by 11
	localparam int CURRENT_SHIFT = 11;
	localparam int VBUS_SHIFT    = 11;

	localparam logic [11:0] RST_COUNTS_PER_REV = 12'd2000;
	localparam logic [15:0] RST_ANGLE_GAIN     = 16'd13177;
	localparam logic [11:0] RST_INDEX_PRESET   = 12'd1500;
	localparam logic [11:0] RST_CURRENT_ZERO   = 12'd2048;
	localparam logic [15:0] RST_CURRENT_GAIN   = 16'd8441;
	localparam logic [15:0] RST_VBUS_GAIN      = 16'd10985;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COUNTS_PER_REV = 3'd0,
		CFG_ANGLE_GAIN     = 3'd1,
		CFG_INDEX_PRESET   = 3'd2,
		CFG_CURRENT_ZERO   = 3'd3,
		CFG_CURRENT_GAIN   = 3'd4,
		CFG_VBUS_GAIN      = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [11:0] counts_per_rev;
		logic [15:0] angle_gain;
		logic [11:0] index_preset;
		logic [11:0] current_zero;
		logic [15:0] current_gain;
		logic [15:0] vbus_gain;
	} cfg_t;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] encoder_delta;
		logic [11:0]        adc_phase_b;
		logic [11:0]        adc_bus;
		logic [11:0]        adc_phase_c;
	} in_item_t;

	typedef struct packed {
		logic [11:0]        position;
		logic signed [12:0] diff_b;
		logic signed [12:0] diff_c;
		logic [11:0]        adc_bus;
	} pos_stage_t;

	typedef struct packed {
		logic [11:0]        position;
		logic [27:0]        angle_prod;
		logic signed [28:0] prod_b;
		logic signed [28:0] prod_c;
		logic [27:0]        bus_prod;
	} mul_stage_t;

	typedef struct packed {
		logic [15:0]        angle;
		logic [11:0]        position;
		logic signed [15:0] current_a;
		logic signed [15:0] current_b;
		logic signed [15:0] current_c;
		logic [15:0]        bus_voltage;
	} out_item_t;

	function automatic logic [15:0] sat_u16(input logic [18:0] v);
		logic [15:0] r;
		r = (v > 19'd65535) ? 16'hFFFF : v[15:0];
		return r;
	endfunction

	function automatic logic signed [15:0] sat_s16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/encoder_angle_current_front_end_unit.sv]
// top level of the encoder angle and phase current front end
// depends on eacfe_pkg, eacfe_cfg, eacfe_pos, eacfe_mul, eacfe_sat
//
//  port group  | direction | word
//  s_axis_*    | in        | sample (tuser 0) or index pulse (tuser 1)
//  m_axis_*    | out       | angle, position, three currents, bus voltage
//  cfg_*       | in        | register index and write data
//
// four register stages: input, position, multiply, saturate/output.
// one word per cycle while the output is not stalled; a sample passes the position, multiply and output stages in turn.
// index pulses load the position in the position stage and leave no result.
// a stalled output holds each full stage up to the nearest empty one; that stage and those behind it keep filling.
// reset clears the valid bits and the position and loads the configuration registers with their reset values.
module encoder_angle_current_front_end_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// encoder_delta[15:0], adc_phase_b[27:16], adc_bus[39:28], adc_phase_c[51:40]
	input  logic [eacfe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// mode[0]
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// angle[15:0], position[27:16], current_a[43:28], current_b[59:44],
	// current_c[75:60], bus_voltage[91:76]
	output logic [eacfe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [eacfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [eacfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import eacfe_pkg::*;

	cfg_t       cfg;
	in_item_t   item_s1;
	pos_stage_t pos_s2;
	mul_stage_t mul_s3;
	out_item_t  res_s4;

	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4 = !v4_q || m_axis_tready;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;

	assign s_axis_tready = rdy1;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= s_axis_tvalid;
			end
			// index pulses end here
			if (rdy2) begin
				v2_q <= v1_q && !item_s1.mode;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (rdy4) begin
				v4_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && rdy1) begin
			item_s1.mode          <= s_axis_tuser;
			item_s1.encoder_delta <= $signed(s_axis_tdata[15:0]);
			item_s1.adc_phase_b   <= s_axis_tdata[27:16];
			item_s1.adc_bus       <= s_axis_tdata[39:28];
			item_s1.adc_phase_c   <= s_axis_tdata[51:40];
		end
	end

	eacfe_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	eacfe_pos u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (v1_q && rdy2),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.out_s2  (pos_s2)
	);

	eacfe_mul u_mul (
		.clk    (clk),
		.en     (v2_q && rdy3),
		.in_s2  (pos_s2),
		.cfg    (cfg),
		.out_s3 (mul_s3)
	);

	eacfe_sat u_sat (
		.clk    (clk),
		.en     (v3_q && rdy4),
		.in_s3  (mul_s3),
		.out_s4 (res_s4)
	);

	assign m_axis_tvalid = v4_q;
	assign m_axis_tdata  = {4'b0, res_s4.bus_voltage, res_s4.current_c, res_s4.current_b,
	                        res_s4.current_a, res_s4.position, res_s4.angle};

endmodule

[rtl/core/eacfe_cfg.sv]
// configuration register file of the encoder front end
// depends on eacfe_pkg
module eacfe_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [eacfe_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [eacfe_pkg::CFG_DATA_W-1:0] wr_data,
	output eacfe_pkg::cfg_t                 cfg
);
	import eacfe_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.counts_per_rev <= RST_COUNTS_PER_REV;
			cfg_q.angle_gain     <= RST_ANGLE_GAIN;
			cfg_q.index_preset   <= RST_INDEX_PRESET;
			cfg_q.current_zero   <= RST_CURRENT_ZERO;
			cfg_q.current_gain   <= RST_CURRENT_GAIN;
			cfg_q.vbus_gain      <= RST_VBUS_GAIN;
		end else if (wr_en) begin
			case (wr_index)
				CFG_COUNTS_PER_REV: cfg_q.counts_per_rev <= wr_data[11:0];
				CFG_ANGLE_GAIN:     cfg_q.angle_gain     <= wr_data;
				CFG_INDEX_PRESET:   cfg_q.index_preset   <= wr_data[11:0];
				CFG_CURRENT_ZERO:   cfg_q.current_zero   <= wr_data[11:0];
				CFG_CURRENT_GAIN:   cfg_q.current_gain   <= wr_data;
				CFG_VBUS_GAIN:      cfg_q.vbus_gain      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/eacfe_pos.sv]
// position tracking stage: accumulate, wrap and clamp the encoder position,
// and form the offset-removed current codes; depends on eacfe_pkg
module eacfe_pos (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  eacfe_pkg::in_item_t   item_s1,
	input  eacfe_pkg::cfg_t       cfg,
	output eacfe_pkg::pos_stage_t out_s2
);
	import eacfe_pkg::*;

	logic [11:0]        pos_q;
	logic [12:0]        cpr;
	logic signed [17:0] cpr_s;
	logic signed [17:0] sum;
	logic signed [17:0] wrapped;
	logic [11:0]        next_pos;
	pos_stage_t         stage_s2;

	// a zero revolution count means a full 4096
	assign cpr   = (cfg.counts_per_rev == 12'd0) ? 13'd4096 : {1'b0, cfg.counts_per_rev};
	assign cpr_s = $signed({5'b0, cpr});
	assign sum   = $signed({6'b0, pos_q})
	             + $signed({{2{item_s1.encoder_delta[15]}}, item_s1.encoder_delta});

	always_comb begin
		if (sum < 18'sd0) begin
			wrapped = sum + cpr_s;
		end else if (sum >= cpr_s) begin
			wrapped = sum - cpr_s;
		end else begin
			wrapped = sum;
		end
		// one wrap is not enough for a large delta: clamp to the valid range
		if (wrapped < 18'sd0) begin
			next_pos = 12'd0;
		end else if (wrapped >= cpr_s) begin
			next_pos = 12'(cpr - 13'd1);
		end else begin
			next_pos = wrapped[11:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 12'd0;
		end else if (en) begin
			pos_q <= item_s1.mode ? cfg.index_preset : next_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s2.position <= next_pos;
			stage_s2.diff_b   <= $signed({1'b0, cfg.current_zero})
			                   - $signed({1'b0, item_s1.adc_phase_b});
			stage_s2.diff_c   <= $signed({1'b0, cfg.current_zero})
			                   - $signed({1'b0, item_s1.adc_phase_c});
			stage_s2.adc_bus  <= item_s1.adc_bus;
		end
	end

	assign out_s2 = stage_s2;

endmodule

[rtl/core/eacfe_mul.sv]
// multiply stage: angle, both phase currents and bus voltage products
// depends on eacfe_pkg
module eacfe_mul (
	input  logic                  clk,
	input  logic                  en,
	input  eacfe_pkg::pos_stage_t in_s2,
	input  eacfe_pkg::cfg_t       cfg,
	output eacfe_pkg::mul_stage_t out_s3
);
	import eacfe_pkg::*;

	logic signed [16:0] cur_gain_s;
	logic signed [29:0] full_b;
	logic signed [29:0] full_c;
	mul_stage_t         stage_s3;

	assign cur_gain_s = $signed({1'b0, cfg.current_gain});
	assign full_b     = in_s2.diff_b * cur_gain_s;
	assign full_c     = in_s2.diff_c * cur_gain_s;

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s3.position   <= in_s2.position;
			stage_s3.angle_prod <= in_s2.position * cfg.angle_gain;
			// |diff| <= 4096 keeps the product inside 29 bits
			stage_s3.prod_b     <= full_b[28:0];
			stage_s3.prod_c     <= full_c[28:0];
			stage_s3.bus_prod   <= in_s2.adc_bus * cfg.vbus_gain;
		end
	end

	assign out_s3 = stage_s3;

endmodule

[rtl/core/eacfe_sat.sv]
// output stage: shift, saturate and derive phase A; holds the result register
// depends on eacfe_pkg
module eacfe_sat (
	input  logic                  clk,
	input  logic                  en,
	input  eacfe_pkg::mul_stage_t in_s3,
	output eacfe_pkg::out_item_t  out_s4
);
	import eacfe_pkg::*;

	logic signed [17:0] ib_raw;
	logic signed [17:0] ic_raw;
	logic signed [15:0] ib;
	logic signed [15:0] ic;
	logic signed [17:0] neg_sum;
	out_item_t          result_s4;

	// arithmetic shift rounds toward minus infinity
	assign ib_raw  = 18'(in_s3.prod_b >>> CURRENT_SHIFT);
	assign ic_raw  = 18'(in_s3.prod_c >>> CURRENT_SHIFT);
	assign ib      = sat_s16(ib_raw);
	assign ic      = sat_s16(ic_raw);
	assign neg_sum = 18'sd0 - ($signed({{2{ib[15]}}, ib}) + $signed({{2{ic[15]}}, ic}));

	always_ff @(posedge clk) begin
		if (en) begin
			result_s4.angle       <= sat_u16(in_s3.angle_prod[27:ANGLE_SHIFT]);
			result_s4.position    <= in_s3.position;
			result_s4.current_a   <= sat_s16(neg_sum);
			result_s4.current_b   <= ib;
			result_s4.current_c   <= ic;
			result_s4.bus_voltage <= sat_u16({2'b0, in_s3.bus_prod[27:VBUS_SHIFT]});
		end
	end

	assign out_s4 = result_s4;

endmodule

[rtl/core/eacfe_chk.sv]
// port-level checker of the encoder front end, bound to the top level
// depends on eacfe_pkg and encoder_angle_current_front_end_unit_defines.svh
`include "encoder_angle_current_front_end_unit_defines.svh"

module eacfe_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [eacfe_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import eacfe_pkg::*;

	logic signed [15:0] cur_a;
	logic signed [15:0] cur_b;
	logic signed [15:0] cur_c;
	logic signed [17:0] neg_bc;
	logic signed [15:0] exp_a;
	logic               out_stall;

	assign cur_a     = $signed(m_axis_tdata[43:28]);
	assign cur_b     = $signed(m_axis_tdata[59:44]);
	assign cur_c     = $signed(m_axis_tdata[75:60]);
	assign neg_bc    = 18'sd0
	                 - ($signed({{2{cur_b[15]}}, cur_b}) + $signed({{2{cur_c[15]}}, cur_c}));
	assign exp_a     = sat_s16(neg_bc);
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	`EACFE_CHECK_RST(a_no_word_in_reset, !arst_n |-> !m_axis_tvalid, "result word during reset")
	`EACFE_CHECK(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
	`EACFE_CHECK(a_empty_takes_input, !m_axis_tvalid |-> s_axis_tready, "input stalled, output empty")
	`EACFE_CHECK(a_phase_a_sum, m_axis_tvalid |-> cur_a == exp_a, "phase A is not minus B plus C")

endmodule

bind encoder_angle_current_front_end_unit eacfe_chk u_eacfe_chk (.*);
